// File: hdl/iklp_pkg.sv
package iklp_pkg;

  localparam int MAX_KEY_CHARS   = 32;
  localparam int MAX_VALUE_CHARS = 255;
  localparam int BUFFER_LIMIT    = 1048576;

  localparam int OFS_W      = 21;
  localparam int CNT_W      = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // saturating key length counter, one past the limit means too long
  localparam int KCNT_W = $clog2(MAX_KEY_CHARS + 2);
  localparam logic [KCNT_W-1:0] KCNT_CAP = KCNT_W'(MAX_KEY_CHARS + 1);

  localparam logic [7:0] MARK0     = 8'hEF;
  localparam logic [7:0] MARK1     = 8'hBB;
  localparam logic [7:0] MARK2     = 8'hBF;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ENTRIES = 1'b0,
    CFG_COUNT_ONLY  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_SKIPPED = 2'd2,
    KIND_NONE    = 2'd3
  } line_kind_t;

  typedef struct packed {
    logic sp;
    logic eol;
    logic nul;
    logic comment;
    logic slash;
    logic eq;
    logic ident_first;
    logic digit;
    logic lbrack;
    logic rbrack;
  } byte_class_t;

  typedef struct packed {
    line_kind_t       line_kind;
    logic [CNT_W-1:0] entry_index;
    logic [OFS_W-1:0] key_start;
    logic [OFS_W-1:0] key_end;
    logic [OFS_W-1:0] value_start;
    logic [OFS_W-1:0] value_end;
    logic [CNT_W-1:0] entries_so_far;
    logic [CNT_W-1:0] skipped_so_far;
    logic             stopped;
    logic             final_res;
  } result_t;

endpackage

// File: hdl/iklp_if.sv
interface iklp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface iklp_out_if import iklp_pkg::*; ();
  logic             valid;
  logic             ready;
  line_kind_t       line_kind;
  logic [CNT_W-1:0] entry_index;
  logic [OFS_W-1:0] key_start;
  logic [OFS_W-1:0] key_end;
  logic [OFS_W-1:0] value_start;
  logic [OFS_W-1:0] value_end;
  logic [CNT_W-1:0] entries_so_far;
  logic [CNT_W-1:0] skipped_so_far;
  logic             stopped;
  logic             final_res;

  modport source (
    output valid, output line_kind, output entry_index, output key_start,
    output key_end, output value_start, output value_end, output entries_so_far,
    output skipped_so_far, output stopped, output final_res, input ready
  );
  modport sink (
    input valid, input line_kind, input entry_index, input key_start,
    input key_end, input value_start, input value_end, input entries_so_far,
    input skipped_so_far, input stopped, input final_res, output ready
  );
endinterface

interface iklp_cfg_if import iklp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/iklp_classify.sv
module iklp_classify import iklp_pkg::*; (
  input  logic [7:0]  data_byte,
  output byte_class_t cls
);

  always_comb begin
    cls.sp          = (data_byte == CH_SP) || (data_byte == CH_TAB);
    cls.eol         = (data_byte == CH_CR) || (data_byte == CH_LF);
    cls.nul         = (data_byte == CH_NUL);
    cls.comment     = data_byte inside {CH_SEMI, CH_HASH, CH_LBRACK};
    cls.slash       = (data_byte == CH_SLASH);
    cls.eq          = (data_byte == CH_EQ);
    cls.ident_first = data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_US};
    cls.digit       = data_byte inside {[8'h30:8'h39]};
    cls.lbrack      = (data_byte == CH_LBRACK);
    cls.rbrack      = (data_byte == CH_RBRACK);
  end

endmodule

// File: hdl/iklp_line_core.sv
module iklp_line_core import iklp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  byte_class_t           cls,
  input  logic [CFG_DATA_W-1:0] max_entries,
  input  logic                  count_only,
  output logic                  res_valid,
  output result_t               res
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_KEY, PH_VLEAD, PH_VAL, PH_IGN
  } phase_t;

  typedef enum logic [2:0] {
    KC_FIRST, KC_NAME, KC_IDX0, KC_IDX, KC_DONE
  } kc_t;

  typedef struct packed {
    phase_t            phase;
    kc_t               kc;
    logic              kv;
    logic [KCNT_W-1:0] kcnt;
    logic [OFS_W-1:0]  kf;
    logic [OFS_W-1:0]  kl;
    logic [OFS_W-1:0]  vf;
    logic [OFS_W-1:0]  vl;
    logic              slash;
    logic              nul;
  } line_t;

  function automatic line_t new_line();
    line_t r;
    r.phase = PH_LEAD;
    r.kc    = KC_FIRST;
    r.kv    = 1'b1;
    r.kcnt  = '0;
    r.kf    = '0;
    r.kl    = '0;
    r.vf    = '0;
    r.vl    = '0;
    r.slash = 1'b0;
    r.nul   = 1'b0;
    return r;
  endfunction

  function automatic line_t key_char(line_t s, byte_class_t k, logic [OFS_W-1:0] p);
    line_t r;
    r = s;
    // key chars must be contiguous
    if (s.kcnt != '0 && p != s.kl) r.kv = 1'b0;
    case (s.kc)
      KC_FIRST: begin
        if (k.ident_first) r.kc = KC_NAME;
        else r.kv = 1'b0;
      end
      KC_NAME: begin
        if (k.lbrack) r.kc = KC_IDX0;
        else if (!(k.ident_first || k.digit)) r.kv = 1'b0;
      end
      KC_IDX0: begin
        if (k.digit) r.kc = KC_IDX;
        else r.kv = 1'b0;
      end
      KC_IDX: begin
        if (k.rbrack) r.kc = KC_DONE;
        else if (!k.digit) r.kv = 1'b0;
      end
      default: r.kv = 1'b0;
    endcase
    r.kl = p + 1'b1;
    if (s.kcnt != KCNT_CAP) r.kcnt = s.kcnt + 1'b1;
    return r;
  endfunction

  function automatic line_t feed(line_t s, byte_class_t k, logic [OFS_W-1:0] p);
    line_t r;
    logic  key_in;
    r      = s;
    key_in = 1'b0;
    if (!s.nul) begin
      r.slash = 1'b0;
      if (k.nul) begin
        r.nul = 1'b1;
      end else begin
        case (s.phase)
          PH_LEAD: begin
            if (k.comment) begin
              r.phase = PH_IGN;
            end else if (!k.sp) begin
              r.kf    = p;
              r.kl    = p;
              r.kcnt  = '0;
              r.phase = PH_KEY;
              if (k.slash) begin
                r.slash = 1'b1;
                key_in  = 1'b1;
              end else if (k.eq) begin
                r.phase = PH_VLEAD;
                r.vf    = p + 1'b1;
                r.vl    = p + 1'b1;
              end else begin
                key_in = 1'b1;
              end
            end
          end
          PH_KEY: begin
            if (s.slash && k.slash) begin
              r.phase = PH_IGN;
            end else if (k.eq) begin
              r.phase = PH_VLEAD;
              r.vf    = p + 1'b1;
              r.vl    = p + 1'b1;
            end else if (!k.sp) begin
              key_in = 1'b1;
            end
          end
          PH_VLEAD: begin
            if (k.sp) begin
              r.vf = p + 1'b1;
              r.vl = p + 1'b1;
            end else begin
              r.vf    = p;
              r.vl    = p + 1'b1;
              r.phase = PH_VAL;
            end
          end
          PH_VAL: begin
            if (!k.sp) r.vl = p + 1'b1;
          end
          default: ;
        endcase
      end
      if (key_in) r = key_char(r, k, p);
    end
    return r;
  endfunction

  line_t            ln;
  logic [OFS_W-1:0] pos;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] skip_count;
  logic             halted;
  logic [1:0]       mark_cnt;

  line_t            ln_next;
  logic [OFS_W-1:0] pos_next;
  logic [CNT_W-1:0] entry_count_next;
  logic [CNT_W-1:0] skip_count_next;
  logic             halted_next;
  logic [1:0]       mark_cnt_next;

  line_t            base;
  line_t            fed;
  logic             in_range;
  logic             active;
  logic             mark_slot;
  logic             mark_hit;
  logic [7:0]       mark_byte;
  logic             dropped;
  logic             take;
  logic             taken;
  logic             do_end;
  logic             ok;
  logic [1:0]       replay;
  logic [OFS_W-1:0] value_len;
  line_kind_t       kind;

  always_comb begin
    in_range  = pos < OFS_W'(BUFFER_LIMIT);
    active    = in_range && !halted;
    mark_slot = active && (mark_cnt != 2'd3) && (pos == OFS_W'(mark_cnt));
    case (mark_cnt)
      2'd0:    mark_byte = MARK0;
      2'd1:    mark_byte = MARK1;
      default: mark_byte = MARK2;
    endcase
    mark_hit = (data_byte == mark_byte);

    mark_cnt_next = mark_cnt;
    take          = active;
    dropped       = 1'b0;
    replay        = 2'd0;
    if (mark_slot) begin
      if (mark_hit && mark_cnt == 2'd2) begin
        mark_cnt_next = 2'd3;
        take          = 1'b0;
        dropped       = 1'b1;
      end else if (mark_hit && !last_byte) begin
        mark_cnt_next = mark_cnt + 2'd1;
        take          = 1'b0;
      end else begin
        replay        = mark_cnt;
        mark_cnt_next = 2'd0;
      end
    end

    // held mark bytes replayed as key data at offsets 0 and 1
    base = ln;
    if (replay != 2'd0) begin
      base.phase = PH_KEY;
      base.kc    = KC_FIRST;
      base.kv    = 1'b0;
      base.kcnt  = KCNT_W'(replay);
      base.kf    = '0;
      base.kl    = OFS_W'(replay);
      base.slash = 1'b0;
      base.nul   = 1'b0;
    end

    taken = take && !cls.eol;
    fed   = taken ? feed(base, cls, pos) : base;

    do_end = (take && cls.eol) ||
             (last_byte && !halted && !dropped && (taken || !in_range));

    value_len = fed.vl - fed.vf;
    ok = fed.kv && (fed.kc == KC_NAME || fed.kc == KC_DONE) &&
         (fed.kcnt <= KCNT_W'(MAX_KEY_CHARS)) &&
         (value_len <= OFS_W'(MAX_VALUE_CHARS));

    ln_next          = fed;
    pos_next         = active ? pos + 1'b1 : pos;
    entry_count_next = entry_count;
    skip_count_next  = skip_count;
    halted_next      = halted;

    res.entry_index = '0;
    res.key_start   = '0;
    res.key_end     = '0;
    res.value_start = '0;
    res.value_end   = '0;
    kind            = KIND_NONE;

    if (do_end) begin
      case (fed.phase)
        PH_KEY: kind = KIND_SKIPPED;
        PH_VLEAD, PH_VAL: begin
          if (!ok) begin
            kind = KIND_SKIPPED;
          end else if (!count_only && entry_count >= CNT_W'(max_entries)) begin
            kind        = KIND_NONE;
            halted_next = 1'b1;
          end else begin
            kind             = KIND_ENTRY;
            res.entry_index  = entry_count;
            res.key_start    = fed.kf;
            res.key_end      = fed.kl;
            res.value_start  = fed.vf;
            res.value_end    = fed.vl;
            entry_count_next = entry_count + 1'b1;
          end
        end
        default: kind = KIND_IGNORED;
      endcase
      if (kind == KIND_SKIPPED) skip_count_next = skip_count + 1'b1;
      ln_next = new_line();
    end

    res.line_kind      = kind;
    res.entries_so_far = entry_count_next;
    res.skipped_so_far = skip_count_next;
    res.stopped        = halted_next;
    res.final_res      = last_byte;
    res_valid          = step && (do_end || last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      ln          <= new_line();
      pos         <= '0;
      entry_count <= '0;
      skip_count  <= '0;
      halted      <= 1'b0;
      mark_cnt    <= 2'd0;
    end else if (step) begin
      ln          <= ln_next;
      pos         <= pos_next;
      entry_count <= entry_count_next;
      skip_count  <= skip_count_next;
      halted      <= halted_next;
      mark_cnt    <= mark_cnt_next;
    end
  end

endmodule

// File: hdl/iklp_out_fifo.sv
module iklp_out_fifo import iklp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    out_valid,
  output result_t out_data,
  output logic    room
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign out_valid = (count != 2'd0);
  assign room      = (count != 2'd2);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/ini_key_value_line_parser.sv
// Result path: a byte is captured in the input register, then the line state update pushes its
// result into a two-entry result queue, which drives results.valid; the update waits while the
// queue is full.
// Throughput: one byte per cycle while results are taken and the result queue has room.
// Reset (rst, synchronous, active high) clears the line and stream state and the
// result queue, and sets max_entries to 65535 and count_only to 0.
module ini_key_value_line_parser import iklp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  iklp_in_if.sink       bytes,
  iklp_out_if.source    results,
  iklp_cfg_if.sink      cfg
);

  logic [CFG_DATA_W-1:0] max_entries;
  logic                  count_only;

  logic        s_valid;
  logic [7:0]  s_byte;
  logic        s_last;
  logic        advance;
  logic        room;

  byte_class_t cls;
  logic        res_valid;
  result_t     res;
  logic        out_valid;
  result_t     out_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= 16'hFFFF;
      count_only  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MAX_ENTRIES: max_entries <= cfg.data;
        CFG_COUNT_ONLY:  count_only  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign advance     = s_valid && room;
  assign bytes.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (bytes.ready) begin
      s_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s_byte <= bytes.data_byte;
      s_last <= bytes.last_byte;
    end
  end

  iklp_classify u_classify (
    .data_byte (s_byte),
    .cls       (cls)
  );

  iklp_line_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (s_byte),
    .last_byte   (s_last),
    .cls         (cls),
    .max_entries (max_entries),
    .count_only  (count_only),
    .res_valid   (res_valid),
    .res         (res)
  );

  iklp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (results.valid && results.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .room      (room)
  );

  assign results.valid          = out_valid;
  assign results.line_kind      = out_data.line_kind;
  assign results.entry_index    = out_data.entry_index;
  assign results.key_start      = out_data.key_start;
  assign results.key_end        = out_data.key_end;
  assign results.value_start    = out_data.value_start;
  assign results.value_end      = out_data.value_end;
  assign results.entries_so_far = out_data.entries_so_far;
  assign results.skipped_so_far = out_data.skipped_so_far;
  assign results.stopped        = out_data.stopped;
  assign results.final_res      = out_data.final_res;

endmodule
